// ----- sv/tpri_pkg.sv -----
// Shared types, constants and helper functions for the time-stamped pose ring.
// Depends on nothing; the divider, the top level and the testbench use it by scoped names.
package tpri_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 256;
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Field widths.
  localparam int TIME_W  = 63;
  localparam int POS_W   = 32;
  localparam int SIGMA_W = 16;
  localparam int FIX_W   = 3;
  localparam int CONF_W  = 9;
  localparam int QUAL_W  = 2;

  // Serial divider: 96-bit dividend, one quotient bit per cycle.
  localparam int DVD_W     = 96;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // One stored fix.
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [POS_W-1:0]   east;
    logic [POS_W-1:0]   north;
    logic [POS_W-1:0]   up;
    logic [SIGMA_W-1:0] sigma;
    logic [FIX_W-1:0]   fix;
    logic               pv;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_IGNORE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_OVERWROTE = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_NONE      = 2'd3
  } pub_status_t;

  typedef enum logic [2:0] {
    GATE_OK        = 3'd0,
    GATE_NO_DATA   = 3'd1,
    GATE_BEFORE    = 3'd2,
    GATE_FUTURE    = 3'd3,
    GATE_LOST      = 3'd4,
    GATE_STALE     = 3'd5,
    GATE_LOW_CONF  = 3'd6,
    GATE_NONE      = 3'd7
  } gate_t;

  typedef enum logic [1:0] {
    REG_MAX_EXTRAP = 2'd0,
    REG_MAX_GAP    = 2'd1,
    REG_MIN_CONF   = 2'd2,
    REG_MIN_QUAL   = 2'd3
  } reg_idx_t;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_PUB_RD  = 18'h00002,
    S_PUB_CMP = 18'h00004,
    S_PUB_WR  = 18'h00008,
    S_Q_FIRST = 18'h00010,
    S_Q_FCHK  = 18'h00020,
    S_Q_LCHK  = 18'h00040,
    S_Q_SRCH  = 18'h00080,
    S_Q_SCMP  = 18'h00100,
    S_Q_RDA   = 18'h00200,
    S_Q_RDB   = 18'h00400,
    S_Q_EVAL  = 18'h00800,
    S_MUL0    = 18'h01000,
    S_MUL1    = 18'h02000,
    S_MUL2    = 18'h04000,
    S_DSTART  = 18'h08000,
    S_DIV     = 18'h10000,
    S_FIN     = 18'h20000
  } state_t;

  // Q8 confidence for a fix type.
  function automatic logic [CONF_W-1:0] conf_q8(input logic [FIX_W-1:0] f);
    logic [CONF_W-1:0] c;
    case (f)
      3'd4:    c = 9'd256;
      3'd3:    c = 9'd179;
      3'd2:    c = 9'd141;
      3'd1:    c = 9'd90;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Quality code for a fix type.
  function automatic logic [QUAL_W-1:0] qual_of(input logic [FIX_W-1:0] f);
    logic [QUAL_W-1:0] q;
    case (f)
      3'd4:    q = 2'd3;
      3'd3:    q = 2'd2;
      3'd2:    q = 2'd2;
      3'd1:    q = 2'd1;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

  // Physical slot of logical entry i, counted from the oldest slot.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] oldest,
                                                input logic [CNT_W-1:0] i);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, oldest} + {1'b0, i};
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- sv/tpri_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tpri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tpri_div.sv -----
// Restoring bit-serial divider: 96-bit dividend by 63-bit divisor, one bit a cycle.
// Depends on tpri_pkg.
module tpri_div (
  input  logic                                clk,
  input  logic                                rst,
  input  tpri_pkg::div_ctl_t                  ctl,
  input  logic [tpri_pkg::DVD_W-1:0]          dividend,
  input  logic [tpri_pkg::TIME_W-1:0]         divisor,
  output tpri_pkg::div_stat_t                 stat,
  output logic [tpri_pkg::DVD_W-1:0]          quotient
);

  logic [tpri_pkg::DVD_W-1:0]     dvd;
  logic [tpri_pkg::TIME_W-1:0]    rem;
  logic [tpri_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [tpri_pkg::TIME_W:0]      rem_sh;
  logic                           fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign rem_sh = {rem, dvd[tpri_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= tpri_pkg::DIV_CNT_W'(tpri_pkg::DVD_W);
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? tpri_pkg::TIME_W'(rem_sh - {1'b0, divisor})
                     : rem_sh[tpri_pkg::TIME_W-1:0];
        dvd  <= {dvd[tpri_pkg::DVD_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == tpri_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

// ----- sv/timestamped_pose_ring_interpolator.sv -----
// Sequencing: a publish reads the newest entry and compares stamps, unless the ring is
// empty, then writes; empty and ignored items are answered from idle; a query checks the
// first and newest entries, searches, reads the bracket and, per axis, runs two multiplier
// passes, an add and the divider. Throughput: one transaction at a time, one divider shared.
// Reset (rst, synchronous): ring emptied, registers at defaults; the fix memory is
// not cleared, since only entries written since the last empty are ever read.
// Top level of the time-stamped pose ring with linear interpolation.
// Depends on tpri_pkg, tpri_ram and tpri_div.
module timestamped_pose_ring_interpolator (
  input  logic                clk,
  input  logic                rst,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [62:0]         stamp_ns,
  input  logic [2:0]          fix_kind,
  input  logic                pose_ok,
  input  logic signed [31:0]  east_mm,
  input  logic signed [31:0]  north_mm,
  input  logic signed [31:0]  up_mm,
  input  logic [15:0]         sigma_mm,
  // Output channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          publish_status,
  output logic [2:0]          gate,
  output logic                pose_out,
  output logic signed [31:0]  out_east_mm,
  output logic signed [31:0]  out_north_mm,
  output logic signed [31:0]  out_up_mm,
  output logic [15:0]         out_sigma_mm,
  output logic [1:0]          quality,
  output logic [8:0]          confidence_q8,
  output logic [62:0]         span_ns
);

  localparam int AW = tpri_pkg::ADDR_W;
  localparam int CW = tpri_pkg::CNT_W;
  localparam int TW = tpri_pkg::TIME_W;

  // Configuration registers.
  logic [31:0] max_extrap;
  logic [31:0] max_gap;
  logic [8:0]  min_conf;
  logic [1:0]  min_qual;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_extrap <= 32'd0;
      max_gap    <= 32'd1000000000;
      min_conf   <= 9'd90;
      min_qual   <= 2'd0;
    end else if (cfg_wr) begin
      case (tpri_pkg::reg_idx_t'(paddr[3:2]))
        tpri_pkg::REG_MAX_EXTRAP: max_extrap <= pwdata;
        tpri_pkg::REG_MAX_GAP:    max_gap    <= pwdata;
        tpri_pkg::REG_MIN_CONF:   min_conf   <= pwdata[8:0];
        tpri_pkg::REG_MIN_QUAL:   min_qual   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (tpri_pkg::reg_idx_t'(paddr[3:2]))
      tpri_pkg::REG_MAX_EXTRAP: prdata = max_extrap;
      tpri_pkg::REG_MAX_GAP:    prdata = max_gap;
      tpri_pkg::REG_MIN_CONF:   prdata = {23'd0, min_conf};
      tpri_pkg::REG_MIN_QUAL:   prdata = {30'd0, min_qual};
      default:                  prdata = 32'd0;
    endcase
  end

  // Sequencer state and working registers.
  tpri_pkg::state_t  state;
  logic [AW-1:0]     oldest;
  logic [CW-1:0]     count;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     ia;
  logic              exact;
  logic [TW-1:0]     t_q;
  tpri_pkg::entry_t  new_e;
  tpri_pkg::entry_t  ea;
  tpri_pkg::entry_t  eb;
  logic [TW-1:0]     gap;
  logic [TW-1:0]     num;
  logic [2:0]        worst;
  logic [1:0]        axis;
  logic [32:0]       mag;
  logic              neg;
  logic [31:0]       a_pos;
  logic [64:0]       p0;
  logic [63:0]       p1;
  logic [95:0]       prod;

  // Memory ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  tpri_pkg::entry_t  rd_e;
  logic [tpri_pkg::ENTRY_W-1:0] rd_bits;

  tpri_ram #(.WIDTH(tpri_pkg::ENTRY_W), .DEPTH(tpri_pkg::RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_e),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  assign rd_e = tpri_pkg::entry_t'(rd_bits);

  // Divider.
  tpri_pkg::div_ctl_t  div_ctl;
  tpri_pkg::div_stat_t div_stat;
  logic [95:0]         quo;

  assign div_ctl.start = (state == tpri_pkg::S_DSTART);

  tpri_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (prod),
    .divisor  (gap),
    .stat     (div_stat),
    .quotient (quo)
  );

  // Search midpoint and bracket index.
  logic [CW-1:0] mid_c;
  logic [CW-1:0] ia_c;
  logic [CW:0]   ia_p1;

  assign mid_c = lo + ((hi - lo) >> 1);
  assign ia_c  = (lo != '0) ? lo - 1'b1 : '0;
  assign ia_p1 = {1'b0, ia} + 1'b1;

  // Read address follows the state: the registered data is there in the cycle after.
  always_comb begin
    case (state)
      tpri_pkg::S_PUB_RD: ram_raddr = tpri_pkg::slot_of(oldest, count - 1'b1);
      tpri_pkg::S_Q_FCHK: ram_raddr = tpri_pkg::slot_of(oldest, count - 1'b1);
      tpri_pkg::S_Q_SRCH: ram_raddr = (lo < hi) ? tpri_pkg::slot_of(oldest, mid_c)
                                                : tpri_pkg::slot_of(oldest, ia_c);
      tpri_pkg::S_Q_RDA:  ram_raddr = tpri_pkg::slot_of(oldest, ia_p1[CW-1:0]);
      default:            ram_raddr = tpri_pkg::slot_of(oldest, '0);
    endcase
  end

  // Write slot: append while not full, else overwrite the oldest.
  logic full;
  assign full      = (count == CW'(tpri_pkg::RING_DEPTH));
  assign ram_we    = (state == tpri_pkg::S_PUB_WR);
  assign ram_waddr = full ? oldest : tpri_pkg::slot_of(oldest, count);

  // Shared multiplier: magnitude of the axis delta by one half of the time offset.
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  assign mul_b = (state == tpri_pkg::S_MUL1) ? num[31:0] : {1'b0, num[62:32]};
  assign mul_p = mag * mul_b;

  // Axis operands.
  logic [31:0] b_pos;
  logic [32:0] diff;
  always_comb begin
    case (axis)
      2'd0:    begin a_pos = ea.east;  b_pos = eb.east;  end
      2'd1:    begin a_pos = ea.north; b_pos = eb.north; end
      default: begin a_pos = ea.up;    b_pos = eb.up;    end
    endcase
  end
  assign diff = {b_pos[31], b_pos} - {a_pos[31], a_pos};

  // Evaluation terms.
  logic [TW-1:0] since_last;
  logic [2:0]    worst_c;
  logic [1:0]    q_worst;
  logic [31:0]   lerp_res;
  assign since_last = t_q - rd_e.stamp;
  assign worst_c    = (ea.fix <= eb.fix) ? ea.fix : eb.fix;
  assign q_worst    = tpri_pkg::qual_of(worst);
  assign lerp_res   = neg ? a_pos - quo[31:0] : a_pos + quo[31:0];

  assign in_ready = (state == tpri_pkg::S_IDLE) && !out_valid;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpri_pkg::S_IDLE;
      out_valid <= 1'b0;
      oldest    <= '0;
      count     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        tpri_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            t_q            <= stamp_ns;
            new_e.stamp    <= stamp_ns;
            new_e.east     <= east_mm;
            new_e.north    <= north_mm;
            new_e.up       <= up_mm;
            new_e.sigma    <= sigma_mm;
            new_e.fix      <= fix_kind;
            new_e.pv       <= pose_ok;
            publish_status <= tpri_pkg::ST_NONE;
            gate           <= tpri_pkg::GATE_NONE;
            pose_out       <= 1'b0;
            out_east_mm    <= '0;
            out_north_mm   <= '0;
            out_up_mm      <= '0;
            out_sigma_mm   <= '0;
            quality        <= '0;
            confidence_q8  <= '0;
            span_ns        <= '0;
            case (tpri_pkg::kind_t'(kind))
              tpri_pkg::KIND_PUBLISH: begin
                state <= (count == '0) ? tpri_pkg::S_PUB_WR : tpri_pkg::S_PUB_RD;
              end
              tpri_pkg::KIND_QUERY: begin
                if (count == '0) begin
                  gate      <= tpri_pkg::GATE_NO_DATA;
                  out_valid <= 1'b1;
                end else begin
                  state <= tpri_pkg::S_Q_FIRST;
                end
              end
              tpri_pkg::KIND_EMPTY: begin
                oldest    <= '0;
                count     <= '0;
                out_valid <= 1'b1;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        tpri_pkg::S_PUB_RD: state <= tpri_pkg::S_PUB_CMP;
        tpri_pkg::S_PUB_CMP: begin
          if (t_q <= rd_e.stamp) begin
            publish_status <= tpri_pkg::ST_REJECTED;
            out_valid      <= 1'b1;
            state          <= tpri_pkg::S_IDLE;
          end else begin
            state <= tpri_pkg::S_PUB_WR;
          end
        end
        tpri_pkg::S_PUB_WR: begin
          if (full) begin
            oldest         <= tpri_pkg::slot_of(oldest, CW'(1));
            publish_status <= tpri_pkg::ST_OVERWROTE;
          end else begin
            count          <= count + 1'b1;
            publish_status <= tpri_pkg::ST_STORED;
          end
          out_valid <= 1'b1;
          state     <= tpri_pkg::S_IDLE;
        end
        tpri_pkg::S_Q_FIRST: state <= tpri_pkg::S_Q_FCHK;
        tpri_pkg::S_Q_FCHK: begin
          if (t_q < rd_e.stamp) begin
            gate      <= tpri_pkg::GATE_BEFORE;
            out_valid <= 1'b1;
            state     <= tpri_pkg::S_IDLE;
          end else begin
            state <= tpri_pkg::S_Q_LCHK;
          end
        end
        tpri_pkg::S_Q_LCHK: begin
          if (t_q > rd_e.stamp) begin
            // Past the newest fix: hold it briefly, else report future.
            if (max_extrap == '0 || since_last > {31'd0, max_extrap}) begin
              gate <= tpri_pkg::GATE_FUTURE;
            end else begin
              confidence_q8 <= tpri_pkg::conf_q8(rd_e.fix);
              if (rd_e.pv) begin
                gate         <= tpri_pkg::GATE_OK;
                pose_out     <= 1'b1;
                out_east_mm  <= rd_e.east;
                out_north_mm <= rd_e.north;
                out_up_mm    <= rd_e.up;
                out_sigma_mm <= rd_e.sigma;
                quality      <= tpri_pkg::qual_of(rd_e.fix);
              end else begin
                gate <= tpri_pkg::GATE_LOW_CONF;
              end
            end
            out_valid <= 1'b1;
            state     <= tpri_pkg::S_IDLE;
          end else begin
            lo    <= '0;
            hi    <= count;
            state <= tpri_pkg::S_Q_SRCH;
          end
        end
        tpri_pkg::S_Q_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= tpri_pkg::S_Q_SCMP;
          end else begin
            ia    <= ia_c;
            state <= tpri_pkg::S_Q_RDA;
          end
        end
        tpri_pkg::S_Q_SCMP: begin
          if (rd_e.stamp <= t_q) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= tpri_pkg::S_Q_SRCH;
        end
        tpri_pkg::S_Q_RDA: begin
          ea    <= rd_e;
          exact <= (rd_e.stamp == t_q) || (ia_p1 >= {1'b0, count});
          state <= tpri_pkg::S_Q_RDB;
        end
        tpri_pkg::S_Q_RDB: begin
          eb    <= exact ? ea : rd_e;
          gap   <= exact ? '0 : rd_e.stamp - ea.stamp;
          num   <= exact ? '0 : t_q - ea.stamp;
          state <= tpri_pkg::S_Q_EVAL;
        end
        tpri_pkg::S_Q_EVAL: begin
          worst          <= worst_c;
          span_ns        <= gap;
          confidence_q8  <= tpri_pkg::conf_q8(worst_c);
          if (!ea.pv || !eb.pv) begin
            // Tracking lost: report whichever end still has a pose.
            gate <= tpri_pkg::GATE_LOST;
            if (ea.pv || eb.pv) begin
              pose_out     <= 1'b1;
              out_east_mm  <= ea.pv ? ea.east  : eb.east;
              out_north_mm <= ea.pv ? ea.north : eb.north;
              out_up_mm    <= ea.pv ? ea.up    : eb.up;
              out_sigma_mm <= ea.pv ? ea.sigma : eb.sigma;
              quality      <= tpri_pkg::qual_of(ea.pv ? ea.fix : eb.fix);
            end
            out_valid <= 1'b1;
            state     <= tpri_pkg::S_IDLE;
          end else begin
            pose_out     <= 1'b1;
            out_sigma_mm <= (ea.sigma > eb.sigma) ? ea.sigma : eb.sigma;
            if (exact) begin
              out_east_mm  <= ea.east;
              out_north_mm <= ea.north;
              out_up_mm    <= ea.up;
              state        <= tpri_pkg::S_FIN;
            end else begin
              axis  <= 2'd0;
              state <= tpri_pkg::S_MUL0;
            end
          end
        end
        tpri_pkg::S_MUL0: begin
          // Sign and magnitude of the delta are fixed for this axis here.
          neg   <= diff[32];
          mag   <= diff[32] ? 33'(-diff) : diff;
          state <= tpri_pkg::S_MUL1;
        end
        tpri_pkg::S_MUL1: begin
          p0    <= mul_p;
          state <= tpri_pkg::S_MUL2;
        end
        tpri_pkg::S_MUL2: begin
          p1    <= mul_p[63:0];
          state <= tpri_pkg::S_DSTART;
        end
        tpri_pkg::S_DSTART: begin
          state <= tpri_pkg::S_DIV;
        end
        tpri_pkg::S_DIV: begin
          if (div_stat.done) begin
            case (axis)
              2'd0:    out_east_mm  <= lerp_res;
              2'd1:    out_north_mm <= lerp_res;
              default: out_up_mm    <= lerp_res;
            endcase
            if (axis == 2'd2) begin
              state <= tpri_pkg::S_FIN;
            end else begin
              axis  <= axis + 1'b1;
              state <= tpri_pkg::S_MUL0;
            end
          end
        end
        tpri_pkg::S_FIN: begin
          quality <= q_worst;
          if (gap > {31'd0, max_gap}) begin
            gate <= tpri_pkg::GATE_STALE;
          end else if (confidence_q8 < min_conf || q_worst < min_qual ||
                       q_worst == 2'd0) begin
            gate <= tpri_pkg::GATE_LOW_CONF;
          end else begin
            gate <= tpri_pkg::GATE_OK;
          end
          out_valid <= 1'b1;
          state     <= tpri_pkg::S_IDLE;
        end
        default: state <= tpri_pkg::S_IDLE;
      endcase
    end
  end

  // The divider's dividend is the full product, summed from the two partial products.
  assign prod = {31'd0, p0} + {p1, 32'd0};

`ifndef SYNTHESIS
  // A new transaction is never taken while a result still waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");

  // The fill count never exceeds the ring depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(tpri_pkg::RING_DEPTH)) else $error("entry count overflow");

  // A result never carries both a publish status and a query gate.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (publish_status == tpri_pkg::ST_NONE || gate == tpri_pkg::GATE_NONE))
    else $error("result mixes publish and query");

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == tpri_pkg::S_DIV) else $error("divider busy out of turn");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the time-stamped pose ring interpolator.
// Depends on tpri_pkg and the timestamped_pose_ring_interpolator RTL.
// A shadow ring predicts every result, which is checked against the block.
module testbench;

  localparam logic [62:0] STAMP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  // One input transaction and one result transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [62:0] stamp;
    logic [2:0]  fix;
    logic        pv;
    logic [31:0] east;
    logic [31:0] north;
    logic [31:0] up;
    logic [15:0] sigma;
  } fix_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  gate;
    logic        pose;
    logic [31:0] east;
    logic [31:0] north;
    logic [31:0] up;
    logic [15:0] sigma;
    logic [1:0]  qual;
    logic [8:0]  conf;
    logic [62:0] gap;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [62:0] stamp_ns = '0;
  logic [2:0] fix_kind = '0;
  logic pose_ok = 1'b0;
  logic signed [31:0] east_mm = '0, north_mm = '0, up_mm = '0;
  logic [15:0] sigma_mm = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] publish_status;
  logic [2:0] gate;
  logic pose_out;
  logic [31:0] out_east_mm, out_north_mm, out_up_mm;
  logic [15:0] out_sigma_mm;
  logic [1:0] quality;
  logic [8:0] confidence_q8;
  logic [62:0] span_ns;

  timestamped_pose_ring_interpolator u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .stamp_ns(stamp_ns),
    .fix_kind(fix_kind), .pose_ok(pose_ok), .east_mm(east_mm),
    .north_mm(north_mm), .up_mm(up_mm), .sigma_mm(sigma_mm),
    .out_valid(out_valid), .out_ready(out_ready), .publish_status(publish_status),
    .gate(gate), .pose_out(pose_out), .out_east_mm(out_east_mm),
    .out_north_mm(out_north_mm), .out_up_mm(out_up_mm), .out_sigma_mm(out_sigma_mm),
    .quality(quality), .confidence_q8(confidence_q8), .span_ns(span_ns)
  );

  always #4 clk = ~clk;

  // Shadow ring and shadow registers.
  logic [62:0] ring_time[tpri_pkg::RING_DEPTH];
  logic [31:0] ring_east[tpri_pkg::RING_DEPTH];
  logic [31:0] ring_north[tpri_pkg::RING_DEPTH];
  logic [31:0] ring_up[tpri_pkg::RING_DEPTH];
  logic [15:0] ring_sigma[tpri_pkg::RING_DEPTH];
  logic [2:0]  ring_fix[tpri_pkg::RING_DEPTH];
  logic        ring_pv[tpri_pkg::RING_DEPTH];
  int ring_oldest = 0;
  int ring_count = 0;
  logic [31:0] cfg_extrap = 32'd0;
  logic [31:0] cfg_max_gap = 32'd1000000000;
  logic [8:0]  cfg_min_conf = 9'd90;
  logic [1:0]  cfg_min_qual = 2'd0;

  fix_item_t pending_items[$];
  answer_t expected_answers[$];
  logic [62:0] gen_times[$];
  fix_item_t cur_item;
  int send_gap = 0;
  int recv_stall = 0;
  bit calm = 1'b0;
  int mismatches = 0;

  function automatic int slot_at(int i);
    return (ring_oldest + i) % tpri_pkg::RING_DEPTH;
  endfunction

  function automatic logic [8:0] conf_for_fix(logic [2:0] f);
    case (f)
      3'd4: return 9'd256;
      3'd3: return 9'd179;
      3'd2: return 9'd141;
      3'd1: return 9'd90;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [1:0] grade_for_fix(logic [2:0] f);
    case (f)
      3'd4: return 2'd3;
      3'd3, 3'd2: return 2'd2;
      3'd1: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  // Copy one stored fix into the pose fields.
  function automatic answer_t with_pose(answer_t a, int s);
    answer_t r;
    r = a;
    r.pose = 1'b1;
    r.east = ring_east[s];
    r.north = ring_north[s];
    r.up = ring_up[s];
    r.sigma = ring_sigma[s];
    r.qual = grade_for_fix(ring_fix[s]);
    return r;
  endfunction

  // a + (b - a) * num / den with the quotient truncated toward zero.
  function automatic logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [62:0] num, logic [62:0] den);
    logic signed [33:0] d;
    logic [33:0] mag;
    logic [127:0] prod;
    logic [127:0] q;
    d = 34'(b) - 34'(a);
    mag = d[33] ? 34'(-d) : 34'(d);
    if (den == 0) return a;
    prod = 128'(mag) * 128'(num);
    q = prod / 128'(den);
    return d[33] ? 32'(a - q[31:0]) : 32'(a + q[31:0]);
  endfunction

  // Works out the result of one accepted transaction and updates the shadow ring.
  function automatic answer_t predict_answer(fix_item_t it);
    answer_t a;
    int s, sf, sl, lo, ia, sa, sb;
    logic exact;
    logic [62:0] gap, tl;
    logic [2:0] worst;
    logic [8:0] conf;
    logic [1:0] q;
    a = '0;
    a.status = tpri_pkg::ST_NONE;
    a.gate = tpri_pkg::GATE_NONE;
    if (it.kind == tpri_pkg::KIND_PUBLISH) begin
      if (ring_count > 0 && it.stamp <= ring_time[slot_at(ring_count - 1)]) begin
        a.status = tpri_pkg::ST_REJECTED;
        return a;
      end
      if (ring_count < tpri_pkg::RING_DEPTH) begin
        s = slot_at(ring_count);
        ring_count++;
        a.status = tpri_pkg::ST_STORED;
      end else begin
        s = ring_oldest;
        ring_oldest = (ring_oldest + 1) % tpri_pkg::RING_DEPTH;
        a.status = tpri_pkg::ST_OVERWROTE;
      end
      ring_time[s] = it.stamp;
      ring_east[s] = it.east;
      ring_north[s] = it.north;
      ring_up[s] = it.up;
      ring_sigma[s] = it.sigma;
      ring_fix[s] = it.fix;
      ring_pv[s] = it.pv;
      return a;
    end
    if (it.kind == tpri_pkg::KIND_EMPTY) begin
      ring_oldest = 0;
      ring_count = 0;
      return a;
    end
    if (it.kind != tpri_pkg::KIND_QUERY) return a;
    if (ring_count == 0) begin
      a.gate = tpri_pkg::GATE_NO_DATA;
      return a;
    end
    sf = slot_at(0);
    sl = slot_at(ring_count - 1);
    if (it.stamp < ring_time[sf]) begin
      a.gate = tpri_pkg::GATE_BEFORE;
      return a;
    end
    // Past the newest fix: hold it briefly or call it future.
    if (it.stamp > ring_time[sl]) begin
      tl = it.stamp - ring_time[sl];
      if (cfg_extrap == 0 || tl > 63'(cfg_extrap)) begin
        a.gate = tpri_pkg::GATE_FUTURE;
        return a;
      end
      a.conf = conf_for_fix(ring_fix[sl]);
      if (ring_pv[sl]) begin
        a = with_pose(a, sl);
        a.gate = tpri_pkg::GATE_OK;
      end else begin
        a.gate = tpri_pkg::GATE_LOW_CONF;
      end
      return a;
    end
    // Last entry not later than the query time.
    lo = 0;
    for (int i = 0; i < ring_count; i++) begin
      if (ring_time[slot_at(i)] <= it.stamp) lo = i + 1;
    end
    ia = (lo > 0) ? lo - 1 : 0;
    sa = slot_at(ia);
    exact = (ring_time[sa] == it.stamp) || (ia + 1 >= ring_count);
    sb = exact ? sa : slot_at(ia + 1);
    gap = exact ? 63'd0 : ring_time[sb] - ring_time[sa];
    a.gap = gap;
    worst = (ring_fix[sa] <= ring_fix[sb]) ? ring_fix[sa] : ring_fix[sb];
    conf = conf_for_fix(worst);
    a.conf = conf;
    // Tracking lost: show whichever end still has a pose.
    if (!ring_pv[sa] || !ring_pv[sb]) begin
      if (ring_pv[sa]) a = with_pose(a, sa);
      else if (ring_pv[sb]) a = with_pose(a, sb);
      a.gate = tpri_pkg::GATE_LOST;
      return a;
    end
    a.pose = 1'b1;
    a.east = blend(ring_east[sa], ring_east[sb], exact ? 63'd0 : it.stamp - ring_time[sa],
                   exact ? 63'd0 : gap);
    a.north = blend(ring_north[sa], ring_north[sb], exact ? 63'd0 : it.stamp - ring_time[sa],
                    exact ? 63'd0 : gap);
    a.up = blend(ring_up[sa], ring_up[sb], exact ? 63'd0 : it.stamp - ring_time[sa],
                 exact ? 63'd0 : gap);
    a.sigma = (ring_sigma[sa] > ring_sigma[sb]) ? ring_sigma[sa] : ring_sigma[sb];
    q = grade_for_fix(worst);
    a.qual = q;
    if (gap > 63'(cfg_max_gap)) a.gate = tpri_pkg::GATE_STALE;
    else if (conf < cfg_min_conf || q < cfg_min_qual || q == 0) a.gate = tpri_pkg::GATE_LOW_CONF;
    else a.gate = tpri_pkg::GATE_OK;
    return a;
  endfunction

  // Sender: offers queued transactions with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.insert(expected_answers.size(), predict_answer(cur_item));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          kind <= cur_item.kind;
          stamp_ns <= cur_item.stamp;
          fix_kind <= cur_item.fix;
          pose_ok <= cur_item.pv;
          east_mm <= cur_item.east;
          north_mm <= cur_item.north;
          up_mm <= cur_item.up;
          sigma_mm <= cur_item.sigma;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(7) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endtask

  // Receiver: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    answer_t exp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("result with no expectation pending");
          mismatches++;
        end else begin
          exp = expected_answers.pop_front();
          check_field("publish_status", exp.status, publish_status);
          check_field("gate", exp.gate, gate);
          check_field("pose_out", exp.pose, pose_out);
          check_field("out_east_mm", exp.east, out_east_mm);
          check_field("out_north_mm", exp.north, out_north_mm);
          check_field("out_up_mm", exp.up, out_up_mm);
          check_field("out_sigma_mm", exp.sigma, out_sigma_mm);
          check_field("quality", exp.qual, quality);
          check_field("confidence_q8", exp.conf, confidence_q8);
          check_field("span_ns", exp.gap, span_ns);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(9) == 0) recv_stall = $urandom_range(1, 12);
      end
    end
  end

  // Queues one transaction and tracks which publishes the ring will keep.
  task automatic add_item(logic [1:0] k, logic [62:0] t, logic [2:0] f, logic pv,
                          logic [31:0] e, logic [31:0] n, logic [31:0] u,
                          logic [15:0] sg);
    fix_item_t it;
    it = '{kind: k, stamp: t, fix: f, pv: pv, east: e, north: n, up: u, sigma: sg};
    pending_items.insert(pending_items.size(), it);
    if (k == tpri_pkg::KIND_PUBLISH && (gen_times.size() == 0 || t > gen_times[$])) begin
      gen_times.insert(gen_times.size(), t);
      if (gen_times.size() > tpri_pkg::RING_DEPTH) void'(gen_times.pop_front());
    end else if (k == tpri_pkg::KIND_EMPTY) begin
      gen_times.delete();
    end
  endtask

  task automatic add_query(logic [62:0] t);
    add_item(tpri_pkg::KIND_QUERY, t, 3'd0, 1'b0, 32'd0, 32'd0, 32'd0, 16'd0);
  endtask

  task automatic add_publish(logic [62:0] t);
    logic [2:0] f;
    f = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    add_item(tpri_pkg::KIND_PUBLISH, t, f, $urandom_range(7) != 0, $urandom, $urandom,
             $urandom, 16'($urandom));
  endtask

  // One random transaction, mostly well-formed publishes and queries in range.
  task automatic add_random_item(bit allow_empty);
    int r, sub;
    logic [63:0] dt, span;
    logic [62:0] first, last;
    r = $urandom_range(99);
    if (gen_times.size() > 0) begin
      first = gen_times[0];
      last = gen_times[$];
    end
    if (r < 45) begin
      if (gen_times.size() == 0) begin
        add_publish(($urandom_range(3) == 0) ? 63'({$urandom, $urandom} >> 2)
                                              : 63'($urandom_range(1000)));
      end else begin
        sub = $urandom_range(99);
        if (sub < 70) dt = $urandom_range(1, 2000);
        else if (sub < 92) dt = $urandom_range(1, 2000000000);
        else dt = ({$urandom, $urandom} >> 24) + 1;
        if (64'(last) + dt > 64'(STAMP_MAX)) begin
          add_item(tpri_pkg::KIND_EMPTY, 63'($urandom), 3'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                   16'd0);
        end else begin
          add_publish(63'(64'(last) + dt));
        end
      end
    end else if (r < 50) begin
      if (gen_times.size() == 0) add_publish(63'($urandom));
      else add_publish((last < 50) ? 63'd0 : last - 63'($urandom_range(50)));
    end else if (r < 96 || (!allow_empty && r < 98)) begin
      if (gen_times.size() == 0) begin
        add_query(63'({$urandom, $urandom}));
      end else begin
        sub = $urandom_range(9);
        if (sub < 5) begin
          span = 64'(last - first);
          add_query(63'(64'(first) + ({$urandom, $urandom} % (span + 1))));
        end else if (sub < 7) begin
          add_query(gen_times[$urandom_range(gen_times.size() - 1)]);
        end else if (sub < 8 && first > 0) begin
          add_query(first - 63'((first > 1000) ? $urandom_range(1, 1000)
                                               : $urandom_range(1, 32'(first))));
        end else if (last < STAMP_MAX - 63'd200000) begin
          add_query(last + 63'($urandom_range(1, 200000)));
        end else begin
          add_query(last);
        end
      end
    end else if (r < 98) begin
      add_item(tpri_pkg::KIND_EMPTY, 63'({$urandom, $urandom}), 3'($urandom), 1'($urandom),
               $urandom, $urandom, $urandom, 16'($urandom));
    end else begin
      add_item(tpri_pkg::KIND_IGNORE, 63'({$urandom, $urandom}), 3'($urandom), 1'($urandom),
               $urandom, $urandom, $urandom, 16'($urandom));
    end
  endtask

  // Register write through the configuration port, then update the shadow copy.
  task automatic write_reg(tpri_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tpri_pkg::REG_MAX_EXTRAP: cfg_extrap = value;
      tpri_pkg::REG_MAX_GAP:    cfg_max_gap = value;
      tpri_pkg::REG_MIN_CONF:   cfg_min_conf = value[8:0];
      tpri_pkg::REG_MIN_QUAL:   cfg_min_qual = value[1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Holds off until every queued transaction has been answered.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  // Main sequence: directed cases, then random phases under several settings.
  initial begin
    logic [31:0] set_extrap[6];
    logic [31:0] set_gap[6];
    logic [31:0] set_conf[6];
    logic [31:0] set_qual[6];
    set_extrap = '{32'd0, 32'd5000, 32'hFFFF_FFFF, $urandom, 32'd2000, 32'd100000};
    set_gap = '{32'hFFFF_FFFF, 32'd1000000000, 32'd0, $urandom, 32'd3000, 32'd1000000};
    set_conf = '{32'd0, 32'd90, 32'd256, 32'd141, 32'd179, 32'd90};
    set_qual = '{32'd0, 32'd1, 32'd3, 32'd2, 32'd2, 32'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty ring, rejects, edges, tracking lost, stale, odd fix types.
    add_query(63'd100);
    add_item(tpri_pkg::KIND_IGNORE, STAMP_MAX, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 16'hFFFF);
    add_item(tpri_pkg::KIND_EMPTY, 63'd0, 3'd0, 1'b0, 32'd0, 32'd0, 32'd0, 16'd0);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd1000, 3'd4, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
             32'd0, 16'hFFFF);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd1000, 3'd4, 1'b1, 32'd1, 32'd1, 32'd1, 16'd1);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd500, 3'd4, 1'b1, 32'd1, 32'd1, 32'd1, 16'd1);
    add_query(63'd999);
    add_query(63'd1000);
    add_query(63'd1001);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd3000, 3'd1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFB, 16'd0);
    add_query(63'd2000);
    add_query(63'd2999);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd4000, 3'd7, 1'b0, 32'd7, 32'd8, 32'd9, 16'd10);
    add_query(63'd3500);
    add_query(63'd4000);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd6000, 3'd3, 1'b1, 32'd600, 32'hFFFF_FC00, 32'd3,
             16'd77);
    add_query(63'd5000);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd2000006000, 3'd2, 1'b1, 32'd5, 32'd6, 32'd7,
             16'd8);
    add_query(63'd1000006000);
    add_item(tpri_pkg::KIND_PUBLISH, 63'd2000006001, 3'd0, 1'b1, 32'd9, 32'd9, 32'd9,
             16'd9);
    add_query(63'd2000006001);
    drain();

    // Holding past the newest fix, up to and just beyond the limit.
    write_reg(tpri_pkg::REG_MAX_EXTRAP, 32'd100);
    add_query(63'd2000006051);
    add_query(63'd2000006101);
    add_query(63'd2000006102);
    add_item(tpri_pkg::KIND_PUBLISH, STAMP_MAX, 3'd4, 1'b0, 32'd1, 32'd2, 32'd3, 16'd4);
    add_query(STAMP_MAX);
    add_query(STAMP_MAX - 63'd1);
    add_item(tpri_pkg::KIND_EMPTY, 63'd0, 3'd0, 1'b0, 32'd0, 32'd0, 32'd0, 16'd0);
    add_query(63'd0);
    drain();

    // Random phases; the second one is the longest and draws no random empties.
    for (int p = 0; p < 6; p++) begin
      write_reg(tpri_pkg::REG_MAX_EXTRAP, set_extrap[p]);
      write_reg(tpri_pkg::REG_MAX_GAP, set_gap[p]);
      write_reg(tpri_pkg::REG_MIN_CONF, set_conf[p]);
      write_reg(tpri_pkg::REG_MIN_QUAL, set_qual[p]);
      calm = (p == 5);
      for (int i = 0; i < ((p == 1) ? 420 : 120); i++) add_random_item(p != 1);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #32000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tpri_pkg.sv
sv/tpri_ram.sv
sv/tpri_div.sv
sv/timestamped_pose_ring_interpolator.sv
tb/testbench.sv
